// File: rtl/rfp_pkg.sv
// Shared types and constants for the register access frame parser.
`default_nettype none

package rfp_pkg;

    // Idle tick counter width and timeout limit width
    localparam int TICK_COUNT_WIDTH = 16;
    localparam int LIMIT_WIDTH      = 16;
    localparam int TICK_CMP_WIDTH   = (TICK_COUNT_WIDTH > LIMIT_WIDTH) ?
                                      TICK_COUNT_WIDTH : LIMIT_WIDTH;

    // Reset value of the timeout limit
    localparam logic [LIMIT_WIDTH-1:0] TIMEOUT_LIMIT_RESET = LIMIT_WIDTH'(1000);

    // Address byte layout
    localparam logic [7:0] ADDR_MASK    = 8'h7F;
    localparam int         WRITE_BIT    = 7;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        REQ_BYTE  = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_ABORT = 2'd2
    } rfp_req_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_HEADER    = 2'd0,
        CFG_DEVICE_ID = 2'd1,
        CFG_TIMEOUT   = 2'd2
    } rfp_cfg_idx_t;

    // Status codes of a result
    typedef enum logic [2:0] {
        RC_WORKING = 3'd0,
        RC_OK      = 3'd1,
        RC_BAD_HDR = 3'd2,
        RC_BAD_ID  = 3'd3,
        RC_BAD_SUM = 3'd4,
        RC_TIMEOUT = 3'd5
    } rfp_code_t;

    // Frame parse phase, one-hot
    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_ID     = 6'b000010,
        PH_ADDR   = 6'b000100,
        PH_COUNT  = 6'b001000,
        PH_DATA   = 6'b010000,
        PH_CHECK  = 6'b100000
    } rfp_phase_t;

    // Configuration seen by the parser
    typedef struct packed {
        logic [7:0]             header_byte;
        logic [7:0]             device_id_byte;
        logic [LIMIT_WIDTH-1:0] timeout_limit;
    } rfp_cfg_t;

    // One result item
    typedef struct packed {
        rfp_code_t  result_code;
        logic [6:0] reg_address;
        logic       is_write;
        logic [7:0] length_field;
        logic [7:0] write_data;
    } rfp_result_t;

endpackage

`default_nettype wire

// File: rtl/rfp_parser.sv
// Frame parser state and single-step update for one accepted transaction.
`default_nettype none

module rfp_parser
    import rfp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step_en,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  rx_byte,
    input  wire rfp_cfg_t    cfg,
    output rfp_result_t      result
);

    rfp_phase_t                  phase_reg, phase_next;
    logic [7:0]                  sum_reg, sum_next;
    logic [6:0]                  addr_reg, addr_next;
    logic                        wr_reg, wr_next;
    logic [7:0]                  len_reg, len_next;
    logic [7:0]                  data_reg, data_next;
    logic [TICK_COUNT_WIDTH-1:0] ticks_reg, ticks_next;
    logic [TICK_COUNT_WIDTH-1:0] ticks_inc;
    rfp_code_t                   code;

    // Saturating tick increment
    assign ticks_inc = (ticks_reg == {TICK_COUNT_WIDTH{1'b1}}) ?
                       ticks_reg : ticks_reg + TICK_COUNT_WIDTH'(1);

    // Step the parser by one transaction
    always_comb begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        addr_next  = addr_reg;
        wr_next    = wr_reg;
        len_next   = len_reg;
        data_next  = data_reg;
        ticks_next = ticks_reg;
        code       = RC_WORKING;

        case (req_type)
            REQ_BYTE: begin
                ticks_next = '0;
                unique case (phase_reg)
                    PH_HEADER: begin
                        if (rx_byte == cfg.header_byte) begin
                            phase_next = PH_ID;
                            sum_next   = rx_byte;
                        end else begin
                            code = RC_BAD_HDR;
                        end
                    end
                    PH_ID: begin
                        if (rx_byte == cfg.device_id_byte) begin
                            phase_next = PH_ADDR;
                            sum_next   = sum_reg + rx_byte;
                        end else begin
                            phase_next = PH_HEADER;
                            code       = RC_BAD_ID;
                        end
                    end
                    PH_ADDR: begin
                        addr_next  = 7'(rx_byte & ADDR_MASK);
                        wr_next    = rx_byte[WRITE_BIT];
                        sum_next   = sum_reg + rx_byte;
                        phase_next = PH_COUNT;
                    end
                    PH_COUNT: begin
                        len_next   = rx_byte;
                        sum_next   = sum_reg + rx_byte;
                        phase_next = wr_reg ? PH_DATA : PH_CHECK;
                    end
                    PH_DATA: begin
                        data_next  = rx_byte;
                        sum_next   = sum_reg + rx_byte;
                        phase_next = PH_CHECK;
                    end
                    default: begin
                        code       = (rx_byte == sum_reg) ? RC_OK : RC_BAD_SUM;
                        phase_next = PH_HEADER;
                    end
                endcase
            end
            REQ_TICK: begin
                // Count idle time only while a frame is open
                if (phase_reg != PH_HEADER) begin
                    if (TICK_CMP_WIDTH'(ticks_inc) > TICK_CMP_WIDTH'(cfg.timeout_limit)) begin
                        phase_next = PH_HEADER;
                        ticks_next = '0;
                        code       = RC_TIMEOUT;
                    end else begin
                        ticks_next = ticks_inc;
                    end
                end
            end
            REQ_ABORT: begin
                phase_next = PH_HEADER;
            end
            default: begin
            end
        endcase
    end

    // Result reflects the held fields after the step
    assign result.result_code  = code;
    assign result.reg_address  = addr_next;
    assign result.is_write     = wr_next;
    assign result.length_field = len_next;
    assign result.write_data   = data_next;

    // Advance state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            sum_reg   <= '0;
            addr_reg  <= '0;
            wr_reg    <= 1'b0;
            len_reg   <= '0;
            data_reg  <= '0;
            ticks_reg <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            addr_reg  <= addr_next;
            wr_reg    <= wr_next;
            len_reg   <= len_next;
            data_reg  <= data_next;
            ticks_reg <= ticks_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/register_access_frame_parser_top.sv
// Results are registered in the result register, or the skid register when stalled.
// Throughput: one transaction per cycle unless m_tready stalls; a two-entry output
// buffer (result and skid registers) lets one more in while a result is stalled.
// Reset (aresetn low, synchronous): parser to header phase, held fields, sum and
// idle counter cleared, output buffer emptied, config to header 0, id 0, limit 1000.
`default_nettype none

module register_access_frame_parser_top
    import rfp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [6:0] reg_address, [7] is_write,
                                        // [15:8] length_field, [23:16] write_data
    output logic [2:0]       m_tuser,   // [2:0] result_code
    // Configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    rfp_cfg_t    cfg_reg;
    rfp_result_t step_result;
    rfp_result_t out_reg;
    rfp_result_t skid_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;
    logic        in_accept;
    logic        out_accept;

    assign cfg_ready  = 1'b1;
    assign s_tready   = !skid_valid_reg;
    assign in_accept  = s_tvalid && s_tready;
    assign out_accept = out_valid_reg && m_tready;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_byte    <= '0;
            cfg_reg.device_id_byte <= '0;
            cfg_reg.timeout_limit  <= TIMEOUT_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_HEADER:    cfg_reg.header_byte    <= cfg_data[7:0];
                CFG_DEVICE_ID: cfg_reg.device_id_byte <= cfg_data[7:0];
                CFG_TIMEOUT:   cfg_reg.timeout_limit  <= cfg_data[LIMIT_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    rfp_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (in_accept),
        .req_type (s_tuser),
        .rx_byte  (s_tdata),
        .cfg      (cfg_reg),
        .result   (step_result)
    );

    // Output buffer valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_accept) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_accept;
            end
        end else if (in_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output buffer payload: drain skid first, else load the new result
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_accept) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (in_accept) begin
                out_reg <= step_result;
            end
        end else if (in_accept) begin
            skid_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.result_code;
    assign m_tdata  = {out_reg.write_data, out_reg.length_field,
                       out_reg.is_write, out_reg.reg_address};

endmodule

`default_nettype wire
